/* hw/rtl/ljpf_pkg.sv */
// Shared widths, types and arithmetic helpers for the Lennard-Jones pair force unit.
`timescale 1ns / 1ps
package ljpf_pkg;

    localparam int FRAC    = 16;             // fractional bits of coordinates and outputs
    localparam int CW      = 32;             // coordinate and register width
    localparam int OW      = 48;             // result width
    localparam int DW      = 34;             // signed difference width
    localparam int MAGW    = 33;             // difference magnitude width
    localparam int SQW     = 66;             // squared magnitude width
    localparam int R2W     = 67;             // r squared width
    localparam int QW      = 64;             // Q32.32 ratio width, also its divider depth
    localparam int DMW     = 65;             // 2*s12 - s6 magnitude width
    localparam int F24W    = 102;            // 24*eps*dm width
    localparam int MW      = 68;             // multiplier operand width
    localparam int MPW     = 136;            // multiplier product width
    localparam int ML      = 34;             // multiplier limb width
    localparam int MLN     = MW / ML;        // limbs per operand
    localparam int NF      = 47;             // force quotient bits
    localparam int FSH     = CW - FRAC;      // bits dropped below the force quotient
    localparam int SATW    = 72;             // magnitude width fed to the output saturator
    localparam int XN      = 13;             // stages between the two dividers
    localparam int MQ_D    = 4;              // mid queue depth
    localparam int MQ_AW   = 2;
    localparam int OQ_D    = 2;              // result queue depth
    localparam int OQ_AW   = 1;

    localparam logic [CW-1:0] FIX_ONE = CW'(1) << FRAC;

    localparam logic [0:0] REG_SIGMA_SQ = 1'b0;
    localparam logic [0:0] REG_EPSILON  = 1'b1;

    typedef struct packed {
        logic                     tc;
        logic [R2W-1:0]           r2;
        logic [2:0][MAGW-1:0]     mag;
        logic [2:0]               dsn;
    } t_geo;

    typedef struct packed {
        t_geo             geo;
        logic [QW-1:0]    q;
        logic [QW-1:0]    s6;
        logic             pneg;
        logic             dneg;
        logic [OW-1:0]    pot;
        logic [OW-1:0]    pres;
    } t_ctx;

    typedef struct packed {
        logic [2:0][OW-1:0] force_v;
        logic [OW-1:0]      pot;
        logic [OW-1:0]      pres;
        logic               tc;
    } t_res;

    // one restoring step: {quotient bit, new remainder}; rem < den on entry
    function automatic logic [R2W:0] div_step(input logic [R2W-1:0] rem, input logic nb,
                                              input logic [R2W-1:0] den);
        logic [R2W:0] t;
        logic [R2W:0] dd;
        t  = {rem, nb};
        dd = {1'b0, den};
        if (t >= dd) begin
            return {1'b1, R2W'(t - dd)};
        end
        return {1'b0, t[R2W-1:0]};
    endfunction

    // product >> 32, saturated to 64 bits
    function automatic logic [QW-1:0] sat64(input logic [MPW-1:0] p);
        if (|p[MPW-1:96]) begin
            return '1;
        end
        return p[95:32];
    endfunction

    // sign and magnitude to saturated 48-bit two's complement
    function automatic logic [OW-1:0] sat48(input logic [SATW-1:0] m, input logic neg);
        logic [OW-1:0] v;
        v = m[OW-1:0];
        if (|m[SATW-1:OW-1]) begin
            return neg ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
        end
        return neg ? (~v + 1'b1) : v;
    endfunction

endpackage

/* hw/rtl/lennard_jones_pair_force.sv */
// Top level of the Lennard-Jones 12-6 pair force unit: ports, settings registers, wiring.
//
//  channel   | handshake          | payload
//  ----------+--------------------+-------------------------------------------------
//  pair in   | push / full        | i_first_*, i_second_*, i_offset_* (Q16.16)
//  result    | empty / pop        | o_force_*, o_potential_half, o_pressure_half,
//            |                    | o_too_close (Q32.16, saturating)
//  settings  | i_cfg_we           | i_cfg_addr, i_cfg_wdata
//
//  One pair beat per cycle sustained while full stays low. A beat passes 3 front stages,
//  the mid queue, 65 stages of the bit-serial ratio divider, 13 product stages, 48 stages
//  of the force dividers and the result queue write before its result shows.
//  Reset is synchronous; both settings return to 1.0.
//  With pop held low the back end freezes once its result queue holds two beats and
//  a third waits to enter it; the mid queue then fills and full rises.
`timescale 1ns / 1ps
module lennard_jones_pair_force (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic signed [ljpf_pkg::CW-1:0]      i_first_x,
    input  logic signed [ljpf_pkg::CW-1:0]      i_first_y,
    input  logic signed [ljpf_pkg::CW-1:0]      i_first_z,
    input  logic signed [ljpf_pkg::CW-1:0]      i_second_x,
    input  logic signed [ljpf_pkg::CW-1:0]      i_second_y,
    input  logic signed [ljpf_pkg::CW-1:0]      i_second_z,
    input  logic signed [ljpf_pkg::CW-1:0]      i_offset_x,
    input  logic signed [ljpf_pkg::CW-1:0]      i_offset_y,
    input  logic signed [ljpf_pkg::CW-1:0]      i_offset_z,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [ljpf_pkg::OW-1:0]      o_force_x,
    output logic signed [ljpf_pkg::OW-1:0]      o_force_y,
    output logic signed [ljpf_pkg::OW-1:0]      o_force_z,
    output logic signed [ljpf_pkg::OW-1:0]      o_potential_half,
    output logic signed [ljpf_pkg::OW-1:0]      o_pressure_half,
    output logic                                o_too_close,
    input  logic                                i_cfg_we,
    input  logic [0:0]                          i_cfg_addr,
    input  logic [ljpf_pkg::CW-1:0]             i_cfg_wdata
);
    import ljpf_pkg::*;

    logic [CW-1:0]  r_sigma_sq, r_epsilon;
    logic           mid_push, mid_full, mid_valid, mid_pop;
    t_geo           geo_f, geo_m;
    t_res           res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sigma_sq <= FIX_ONE;
            r_epsilon  <= FIX_ONE;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_SIGMA_SQ: r_sigma_sq <= i_cfg_wdata;
                REG_EPSILON:  r_epsilon  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    ljpf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_full   (full),
        .i_first  ({i_first_z,  i_first_y,  i_first_x}),
        .i_second ({i_second_z, i_second_y, i_second_x}),
        .i_offset ({i_offset_z, i_offset_y, i_offset_x}),
        .o_valid  (mid_push),
        .o_geo    (geo_f),
        .i_stall  (mid_full)
    );

    ljpf_mid_q u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mid_push),
        .i_data  (geo_f),
        .o_full  (mid_full),
        .o_valid (mid_valid),
        .o_data  (geo_m),
        .i_pop   (mid_pop)
    );

    ljpf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_valid (mid_valid),
        .i_mid       (geo_m),
        .o_mid_pop   (mid_pop),
        .i_sigma_sq  (r_sigma_sq),
        .i_epsilon   (r_epsilon),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_res       (res)
    );

    assign o_force_x        = res.force_v[0];
    assign o_force_y        = res.force_v[1];
    assign o_force_z        = res.force_v[2];
    assign o_potential_half = res.pot;
    assign o_pressure_half  = res.pres;
    assign o_too_close      = res.tc;

endmodule

/* hw/rtl/ljpf_mul.sv */
// Two-stage unsigned 68x68 multiplier built from 34x34 partial products.
`timescale 1ns / 1ps
module ljpf_mul (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [ljpf_pkg::MW-1:0]     i_a,
    input  logic [ljpf_pkg::MW-1:0]     i_b,
    output logic [ljpf_pkg::MPW-1:0]    o_p
);
    import ljpf_pkg::*;

    logic [2*ML-1:0] r_pp [MLN][MLN];
    logic [MPW-1:0]  r_p;
    logic [MPW-1:0]  n_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < MLN; i++) begin
                for (int j = 0; j < MLN; j++) begin
                    r_pp[i][j] <= (2*ML)'(i_a[i*ML +: ML]) * (2*ML)'(i_b[j*ML +: ML]);
                end
            end
        end
    end

    always_comb begin
        n_p = '0;
        for (int i = 0; i < MLN; i++) begin
            for (int j = 0; j < MLN; j++) begin
                n_p = n_p + (MPW'(r_pp[i][j]) << (ML * (i + j)));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_p;
        end
    end

    assign o_p = r_p;

endmodule

/* hw/rtl/ljpf_front.sv */
// Front end: takes pair beats, forms the difference vector, r squared and the coincidence flag.
`timescale 1ns / 1ps
module ljpf_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    output logic                                o_full,
    input  logic [2:0][ljpf_pkg::CW-1:0]        i_first,
    input  logic [2:0][ljpf_pkg::CW-1:0]        i_second,
    input  logic [2:0][ljpf_pkg::CW-1:0]        i_offset,
    output logic                                o_valid,
    output ljpf_pkg::t_geo                      o_geo,
    input  logic                                i_stall
);
    import ljpf_pkg::*;

    logic                   fadv;
    logic                   r_av, r_bv, r_cv;
    logic [2:0][MAGW-1:0]   r_amag, r_bmag;
    logic [2:0]             r_adsn, r_bdsn;
    logic [SQW-1:0]         r_bsq [3];
    t_geo                   r_c;
    logic [2:0][MAGW-1:0]   n_mag;
    logic [2:0]             n_dsn;
    logic [R2W-1:0]         n_r2;

    assign fadv   = !r_cv || !i_stall;
    assign o_full = !fadv;

    always_comb begin
        logic signed [DW-1:0] dv;
        for (int k = 0; k < 3; k++) begin
            dv = DW'($signed(i_second[k])) + DW'($signed(i_offset[k]))
                 - DW'($signed(i_first[k]));
            n_dsn[k] = dv[DW-1];
            n_mag[k] = dv[DW-1] ? MAGW'(-dv) : MAGW'(dv);
        end
    end

    assign n_r2 = R2W'(r_bsq[0]) + R2W'(r_bsq[1]) + R2W'(r_bsq[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av <= 1'b0;
            r_bv <= 1'b0;
            r_cv <= 1'b0;
        end else if (fadv) begin
            r_av <= i_push;
            r_bv <= r_av;
            r_cv <= r_bv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fadv) begin
            r_amag <= n_mag;
            r_adsn <= n_dsn;
            r_bmag <= r_amag;
            r_bdsn <= r_adsn;
            for (int k = 0; k < 3; k++) begin
                r_bsq[k] <= SQW'(r_amag[k]) * SQW'(r_amag[k]);
            end
            r_c.r2  <= n_r2;
            r_c.tc  <= (n_r2 == '0);
            r_c.mag <= r_bmag;
            r_c.dsn <= r_bdsn;
        end
    end

    assign o_valid = r_cv;
    assign o_geo   = r_c;

endmodule

/* hw/rtl/ljpf_mid_q.sv */
// Four-entry queue decoupling the front end from the force pipeline.
`timescale 1ns / 1ps
module ljpf_mid_q (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  ljpf_pkg::t_geo      i_data,
    output logic                o_full,
    output logic                o_valid,
    output ljpf_pkg::t_geo      o_data,
    input  logic                i_pop
);
    import ljpf_pkg::*;

    t_geo               r_mem [MQ_D];
    logic [MQ_AW-1:0]   r_wp, r_rp;
    logic [MQ_AW:0]     r_cnt;
    logic               push, pop;

    assign o_full  = (r_cnt == (MQ_AW+1)'(MQ_D));
    assign o_valid = (r_cnt != '0);
    assign push    = i_push && !o_full;
    assign pop     = i_pop && o_valid;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (MQ_AW+1)'(push) - (MQ_AW+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

/* hw/rtl/ljpf_back.sv */
// Back end: ratio divider, power products, energy terms, force dividers and result queue.
`timescale 1ns / 1ps
module ljpf_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_mid_valid,
    input  ljpf_pkg::t_geo              i_mid,
    output logic                        o_mid_pop,
    input  logic [ljpf_pkg::CW-1:0]     i_sigma_sq,
    input  logic [ljpf_pkg::CW-1:0]     i_epsilon,
    output logic                        o_empty,
    input  logic                        i_pop,
    output ljpf_pkg::t_res              o_res
);
    import ljpf_pkg::*;

    logic adv;

    // ratio divider: sigma^2 * 2^(F+32) / r2
    logic [QW:0]        r_qv;
    t_geo               r_qg   [QW+1];
    logic [R2W-1:0]     r_qrem [QW+1];
    logic [QW-1:0]      r_qnq  [QW+1];
    logic               r_qsat [QW+1];
    logic [CW-1:0]      qhi;
    logic [QW-1:0]      q_fin;

    // product stages
    logic [XN-1:0]      r_xv;
    t_ctx               r_x [XN];
    t_ctx               n_x0;
    t_ctx               n_x4, n_x6, n_x9;
    logic [QW-1:0]      r_pm;
    logic [DMW-1:0]     r_dm;
    logic [F24W-1:0]    r_f24;
    logic [MPW-1:0]     r_n [3];
    logic [MPW-1:0]     p1, p2, p3, pep, ped;
    logic [MPW-1:0]     plo [3];
    logic [MPW-1:0]     phi [3];
    logic [QW-1:0]      s12;
    logic [DMW-1:0]     a2;
    logic               n_pneg, n_dneg;
    logic [MPW-1:0]     t12;

    // force dividers
    logic [NF:0]        r_fv;
    t_ctx               r_fg   [NF+1];
    logic [R2W-1:0]     r_frem [NF+1][3];
    logic [NF-1:0]      r_fnq  [NF+1][3];
    logic [2:0]         r_fsat [NF+1];

    // result queue
    t_res               r_oq [OQ_D];
    logic [OQ_AW-1:0]   r_owp, r_orp;
    logic [OQ_AW:0]     r_ocnt;
    logic               ofull, opush, opop;
    t_res               n_res;

    assign ofull     = (r_ocnt == (OQ_AW+1)'(OQ_D));
    assign adv       = !r_fv[NF] || !ofull;
    assign opush     = r_fv[NF] && !ofull;
    assign opop      = i_pop && !o_empty;
    assign o_mid_pop = adv && i_mid_valid;

    // ---------------- ratio divider ----------------
    assign qhi = i_sigma_sq >> FSH;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qv <= '0;
        end else if (adv) begin
            r_qv <= {r_qv[QW-1:0], i_mid_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_qg[0]   <= i_mid;
            r_qsat[0] <= (R2W'(qhi) >= i_mid.r2);
            r_qrem[0] <= R2W'(qhi);
            r_qnq[0]  <= QW'(i_sigma_sq[FSH-1:0]) << (QW - FSH);
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_qdiv
        logic [R2W:0] st;
        assign st = div_step(r_qrem[k-1], r_qnq[k-1][QW-1], r_qg[k-1].r2);
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_qg[k]   <= r_qg[k-1];
                r_qsat[k] <= r_qsat[k-1];
                r_qrem[k] <= st[R2W-1:0];
                r_qnq[k]  <= {r_qnq[k-1][QW-2:0], st[R2W]};
            end
        end
    end

    assign q_fin = r_qsat[QW] ? '1 : r_qnq[QW];

    // ---------------- products ----------------
    always_comb begin
        n_x0     = '0;
        n_x0.geo = r_qg[QW];
        n_x0.q   = q_fin;
    end

    ljpf_mul u_mul_qq (.i_clk(i_clk), .i_en(adv), .i_a(MW'(q_fin)), .i_b(MW'(q_fin)),
                       .o_p(p1));
    ljpf_mul u_mul_q3 (.i_clk(i_clk), .i_en(adv), .i_a(MW'(sat64(p1))), .i_b(MW'(r_x[1].q)),
                       .o_p(p2));
    ljpf_mul u_mul_s12 (.i_clk(i_clk), .i_en(adv), .i_a(MW'(sat64(p2))),
                        .i_b(MW'(sat64(p2))), .o_p(p3));
    ljpf_mul u_mul_ep (.i_clk(i_clk), .i_en(adv), .i_a(MW'(i_epsilon)), .i_b(MW'(r_pm)),
                       .o_p(pep));
    ljpf_mul u_mul_ed (.i_clk(i_clk), .i_en(adv), .i_a(MW'(i_epsilon)), .i_b(MW'(r_dm)),
                       .o_p(ped));

    for (genvar i = 0; i < 3; i++) begin : g_fmul
        ljpf_mul u_mul_lo (.i_clk(i_clk), .i_en(adv), .i_a(r_f24[MW-1:0]),
                           .i_b(MW'(r_x[9].geo.mag[i])), .o_p(plo[i]));
        ljpf_mul u_mul_hi (.i_clk(i_clk), .i_en(adv), .i_a(MW'(r_f24[F24W-1:MW])),
                           .i_b(MW'(r_x[9].geo.mag[i])), .o_p(phi[i]));
    end

    assign s12    = sat64(p3);
    assign a2     = {s12, 1'b0};
    assign n_pneg = (s12 < r_x[5].s6);
    assign n_dneg = (a2 < DMW'(r_x[5].s6));
    assign t12    = (ped << 3) + (ped << 2);

    always_comb begin
        n_x4      = r_x[3];
        n_x4.s6   = sat64(p2);
        n_x6      = r_x[5];
        n_x6.pneg = n_pneg;
        n_x6.dneg = n_dneg;
        n_x9      = r_x[8];
        n_x9.pot  = sat48(pep[102:31], r_x[8].pneg);
        n_x9.pres = sat48(t12[103:32], r_x[8].dneg);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xv <= '0;
        end else if (adv) begin
            r_xv <= {r_xv[XN-2:0], r_qv[QW]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_x[0]       <= n_x0;
            r_x[1]       <= r_x[0];
            r_x[2]       <= r_x[1];
            r_x[3]       <= r_x[2];
            r_x[4]       <= n_x4;
            r_x[5]       <= r_x[4];
            r_x[6]       <= n_x6;
            r_pm         <= n_pneg ? (r_x[5].s6 - s12) : (s12 - r_x[5].s6);
            r_dm         <= n_dneg ? (DMW'(r_x[5].s6) - a2) : (a2 - DMW'(r_x[5].s6));
            r_x[7]       <= r_x[6];
            r_x[8]       <= r_x[7];
            r_x[9]       <= n_x9;
            r_f24        <= {t12[F24W-2:0], 1'b0};
            r_x[10]      <= r_x[9];
            r_x[11]      <= r_x[10];
            r_x[12]      <= r_x[11];
            for (int i = 0; i < 3; i++) begin
                r_n[i] <= plo[i] + {phi[i][MPW-MW-1:0], {MW{1'b0}}};
            end
        end
    end

    // ---------------- force dividers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= '0;
        end else if (adv) begin
            r_fv <= {r_fv[NF-1:0], r_xv[XN-1]};
        end
    end

    always_ff @(posedge i_clk) begin
        logic [MPW-1:0] sh;
        if (adv) begin
            r_fg[0] <= r_x[XN-1];
            for (int i = 0; i < 3; i++) begin
                sh = r_n[i] >> (FSH + NF);
                r_fsat[0][i] <= (sh >= MPW'(r_x[XN-1].geo.r2));
                r_frem[0][i] <= R2W'(sh);
                r_fnq[0][i]  <= r_n[i][FSH +: NF];
            end
        end
    end

    for (genvar k = 1; k <= NF; k++) begin : g_fdiv
        for (genvar i = 0; i < 3; i++) begin : g_lane
            logic [R2W:0] st;
            assign st = div_step(r_frem[k-1][i], r_fnq[k-1][i][NF-1], r_fg[k-1].geo.r2);
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_frem[k][i] <= st[R2W-1:0];
                    r_fnq[k][i]  <= {r_fnq[k-1][i][NF-2:0], st[R2W]};
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_fg[k]   <= r_fg[k-1];
                r_fsat[k] <= r_fsat[k-1];
            end
        end
    end

    // ---------------- formatting and result queue ----------------
    always_comb begin
        logic [SATW-1:0] fm;
        logic            tc;
        tc       = r_fg[NF].geo.tc;
        n_res.tc = tc;
        for (int i = 0; i < 3; i++) begin
            fm           = SATW'(r_fnq[NF][i]);
            fm[SATW-1]   = r_fsat[NF][i];
            n_res.force_v[i] = tc ? '0
                             : sat48(fm, r_fg[NF].dneg ^ r_fg[NF].geo.dsn[i]);
        end
        n_res.pot  = tc ? '0 : r_fg[NF].pot;
        n_res.pres = tc ? '0 : r_fg[NF].pres;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= '0;
            r_orp  <= '0;
            r_ocnt <= '0;
        end else begin
            if (opush) begin
                r_owp <= r_owp + 1'b1;
            end
            if (opop) begin
                r_orp <= r_orp + 1'b1;
            end
            r_ocnt <= r_ocnt + (OQ_AW+1)'(opush) - (OQ_AW+1)'(opop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (opush) begin
            r_oq[r_owp] <= n_res;
        end
    end

    assign o_empty = (r_ocnt == '0);
    assign o_res   = r_oq[r_orp];

endmodule
